/* rtl/bba_pkg.sv */
// bba_pkg: constants, codes, types and helpers of the buddy block allocator
// used by bba_tree, buddy_block_allocator and bba_checker; no dependencies
package bba_pkg;

    localparam int MIN_ORDER    = 8;
    localparam int MAX_ORDER    = 18;
    localparam int HEADER_BYTES = 12;
    localparam int SEG_RESET    = 15;

    localparam int AW      = 18;
    localparam int SIZE_W  = 13;
    localparam int ORD_W   = 5;
    localparam int FRAG_W  = 31;
    localparam int NODE_W  = MAX_ORDER - MIN_ORDER + 1;
    localparam int LEAF_W  = MAX_ORDER - MIN_ORDER;
    localparam int BO_W    = 4;
    localparam int WASTE_W = SIZE_W + 1;

    localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(128);
    localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(4096);
    localparam logic [FRAG_W-1:0] FRAG_MAX = {FRAG_W{1'b1}};

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_NOMEM = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_SPLIT,
        S_FRAG,
        S_FREE_RD,
        S_FREE_ALIGN,
        S_MERGE_RD,
        S_MERGE_CHK,
        S_MERGE_CLR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] waddr;
        logic              wdata;
        logic [NODE_W-1:0] raddr;
    } t_tree_req;

    function automatic logic [ORD_W-1:0] seg_clamp(input logic [ORD_W-1:0] seg);
        logic [ORD_W-1:0] s;
        s = seg;
        if (s < ORD_W'(MIN_ORDER)) s = ORD_W'(MIN_ORDER);
        if (s > ORD_W'(MAX_ORDER)) s = ORD_W'(MAX_ORDER);
        return s;
    endfunction

    function automatic logic [NODE_W-1:0] node_of(input logic [ORD_W-1:0] ord,
                                                  input logic [AW-1:0] addr);
        logic [NODE_W-1:0] base;
        base = NODE_W'(1) << (ORD_W'(MAX_ORDER) - ord);
        return base + NODE_W'(addr >> ord);
    endfunction

endpackage

/* rtl/bba_tree.sv */
// bba_tree: one-bit free flag per buddy tree node, with clearing sweep
// depends on bba_pkg
module bba_tree import bba_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_init,
    input  logic [NODE_W-1:0] i_init_node,
    input  t_tree_req         i_req,
    output logic              o_rd_bit,
    output logic              o_busy
);

    localparam int DEPTH = 2 ** NODE_W;

    logic              r_mem [DEPTH];
    logic              r_q;
    logic              r_busy;
    logic              r_last;
    logic [NODE_W-1:0] r_idx;
    logic [NODE_W-1:0] r_init_node;

    logic              mem_we;
    logic [NODE_W-1:0] mem_waddr;
    logic              mem_wdata;

    always_comb begin
        if (r_busy) begin
            mem_we    = 1'b1;
            mem_waddr = r_last ? r_init_node : r_idx;
            mem_wdata = r_last;
        end else begin
            mem_we    = i_req.we;
            mem_waddr = i_req.waddr;
            mem_wdata = i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b1;
            r_last      <= 1'b0;
            r_idx       <= '0;
            r_init_node <= node_of(seg_clamp(ORD_W'(SEG_RESET)), '0);
        end else if (i_init) begin
            r_busy      <= 1'b1;
            r_last      <= 1'b0;
            r_idx       <= '0;
            r_init_node <= i_init_node;
        end else if (r_busy) begin
            if (r_last) begin
                r_busy <= 1'b0;
                r_last <= 1'b0;
            end else begin
                r_idx <= r_idx + NODE_W'(1);
                if (r_idx == {NODE_W{1'b1}}) begin
                    r_last <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_q <= r_mem[i_req.raddr];
    end

    assign o_rd_bit = r_q;
    assign o_busy   = r_busy;

endmodule

/* rtl/buddy_block_allocator.sv */
// buddy_block_allocator: binary buddy allocator over a 2^order byte segment
// depends on bba_pkg and bba_tree
//
// input channel i_in_valid/o_in_ready carries one request: opcode 0 allocates
// i_req_size bytes, opcode 1 frees i_free_addr. output channel
// o_out_valid/i_out_ready returns one result per request: status, address
// (block offset plus header, 0 on error or free) and fragmentation total.
// the free tree is a one-bit memory probed one node at a time by a
// small sequencer. an allocate probes nodes, then splits; a search may scan
// all 2047 nodes. a free merges up at most 10 levels. one request is
// handled at a time. after reset and after every write of i_cfg_data the
// tree is swept clear, and o_in_ready stays low meanwhile. a stalled
// result is held in the output register; the next request may be accepted
// while it waits, and its result waits in turn until the register frees.
module buddy_block_allocator import bba_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ORD_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_opcode,
    input  logic [SIZE_W-1:0] i_req_size,
    input  logic [AW-1:0]     i_free_addr,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_status,
    output logic [AW-1:0]     o_alloc_addr,
    output logic [FRAG_W-1:0] o_frag_total
);

    t_state            r_state, n_state;
    logic [ORD_W-1:0]  r_seg;
    logic              r_op, n_op;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [AW-1:0]     r_faddr, n_faddr;
    logic [ORD_W-1:0]  r_k, n_k;
    logic [ORD_W-1:0]  r_j, n_j;
    logic [LEAF_W-1:0] r_idx, n_idx;
    logic [AW-1:0]     r_addr, n_addr;
    t_status           r_stat, n_stat;
    logic [AW-1:0]     r_raddr, n_raddr;
    logic [FRAG_W-1:0] r_frag, n_frag;
    logic              r_ovalid;
    t_status           r_ostat;
    logic [AW-1:0]     r_oaddr;
    logic [FRAG_W-1:0] r_ofrag;

    logic [BO_W-1:0]   r_bo_mem [2 ** LEAF_W];
    logic [BO_W-1:0]   r_bo_q;
    logic              bo_we;

    t_tree_req         tree_req;
    logic              tree_bit;
    logic              tree_busy;

    logic              in_acc;
    logic              out_free;
    logic [ORD_W-1:0]  seg_s;
    logic [AW-1:0]     seg_mask;
    logic [SIZE_W:0]   need;
    logic [ORD_W-1:0]  k_round;
    logic [LEAF_W:0]   lvl_count;
    logic [AW-1:0]     srch_addr;
    logic [ORD_W-1:0]  free_ord;
    logic [WASTE_W-1:0] waste;
    logic [FRAG_W:0]   frag_sum;
    logic [ORD_W-1:0]  j_dn;

    assign seg_s     = seg_clamp(r_seg);
    assign seg_mask  = ~({AW{1'b1}} << seg_s);
    assign in_acc    = i_in_valid && o_in_ready;
    assign out_free  = !r_ovalid || i_out_ready;
    assign need      = {1'b0, r_size} + (SIZE_W+1)'(HEADER_BYTES);
    assign lvl_count = (LEAF_W+1)'(1) << (seg_s - r_j);
    assign srch_addr = AW'(r_idx) << r_j;
    assign waste     = (WASTE_W'(1) << r_k) - WASTE_W'(r_size)
                       - WASTE_W'(HEADER_BYTES);
    assign frag_sum  = {1'b0, r_frag} + (FRAG_W+1)'(waste);
    assign j_dn      = r_j - ORD_W'(1);

    always_comb begin
        k_round = ORD_W'(MIN_ORDER);
        for (int c = MIN_ORDER + 1; c <= SIZE_W + 1; c++) begin
            if (need > (SIZE_W+1)'(1 << (c - 1))) k_round = ORD_W'(c);
        end
    end

    always_comb begin
        free_ord = ORD_W'(r_bo_q) + ORD_W'(MIN_ORDER);
        if (free_ord > seg_s) free_ord = seg_s;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:       if (in_acc) n_state = S_CHECK;
            S_CHECK: begin
                if (r_op == OP_FREE) n_state = S_FREE_RD;
                else if (r_size < SIZE_MIN || r_size > SIZE_MAX) n_state = S_DONE;
                else if (k_round > seg_s) n_state = S_DONE;
                else n_state = S_SRCH_RD;
            end
            S_SRCH_RD:    n_state = S_SRCH_CHK;
            S_SRCH_CHK: begin
                if (tree_bit) n_state = S_SPLIT;
                else if ({1'b0, r_idx} + (LEAF_W+1)'(1) == lvl_count && r_j == seg_s)
                    n_state = S_DONE;
                else n_state = S_SRCH_RD;
            end
            S_SPLIT:      if (r_j == r_k) n_state = S_FRAG;
            S_FRAG:       n_state = S_DONE;
            S_FREE_RD:    n_state = S_FREE_ALIGN;
            S_FREE_ALIGN: n_state = S_MERGE_RD;
            S_MERGE_RD:   n_state = (r_j == seg_s) ? S_DONE : S_MERGE_CHK;
            S_MERGE_CHK:  n_state = tree_bit ? S_MERGE_CLR : S_DONE;
            S_MERGE_CLR:  n_state = S_MERGE_RD;
            S_DONE:       if (out_free) n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    // datapath registers
    always_comb begin
        n_op    = r_op;
        n_size  = r_size;
        n_faddr = r_faddr;
        n_k     = r_k;
        n_j     = r_j;
        n_idx   = r_idx;
        n_addr  = r_addr;
        n_stat  = r_stat;
        n_raddr = r_raddr;
        n_frag  = r_frag;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op    = i_opcode;
                    n_size  = i_req_size;
                    n_faddr = i_free_addr;
                end
                n_stat  = STAT_OK;
                n_raddr = '0;
            end
            S_CHECK: begin
                if (r_op == OP_FREE) begin
                    n_addr = (r_faddr - AW'(HEADER_BYTES)) & seg_mask;
                end else if (r_size < SIZE_MIN || r_size > SIZE_MAX) begin
                    n_stat = STAT_RANGE;
                end else if (k_round > seg_s) begin
                    n_stat = STAT_NOMEM;
                end else begin
                    n_k   = k_round;
                    n_j   = k_round;
                    n_idx = '0;
                end
            end
            S_SRCH_CHK: begin
                if (tree_bit) begin
                    n_addr = srch_addr;
                end else if ({1'b0, r_idx} + (LEAF_W+1)'(1) == lvl_count) begin
                    if (r_j == seg_s) n_stat = STAT_NOMEM;
                    n_j   = r_j + ORD_W'(1);
                    n_idx = '0;
                end else begin
                    n_idx = r_idx + LEAF_W'(1);
                end
            end
            S_SPLIT:      if (r_j != r_k) n_j = j_dn;
            S_FRAG: begin
                n_frag  = (frag_sum > {1'b0, FRAG_MAX}) ? FRAG_MAX : frag_sum[FRAG_W-1:0];
                n_raddr = r_addr + AW'(HEADER_BYTES);
            end
            S_FREE_ALIGN: begin
                n_j    = free_ord;
                n_addr = r_addr & ({AW{1'b1}} << free_ord);
            end
            S_MERGE_CLR: begin
                n_addr = r_addr & ~(AW'(1) << r_j);
                n_j    = r_j + ORD_W'(1);
            end
            default: ;
        endcase
    end

    // memory requests
    always_comb begin
        tree_req       = '0;
        tree_req.raddr = node_of(r_j, srch_addr);
        bo_we          = 1'b0;
        case (r_state)
            S_SRCH_CHK: begin
                if (tree_bit) begin
                    tree_req.we    = 1'b1;
                    tree_req.waddr = node_of(r_j, srch_addr);
                    tree_req.wdata = 1'b0;
                end
            end
            S_SPLIT: begin
                if (r_j != r_k) begin
                    tree_req.we    = 1'b1;
                    tree_req.waddr = node_of(j_dn, r_addr + (AW'(1) << j_dn));
                    tree_req.wdata = 1'b1;
                end else begin
                    bo_we = 1'b1;
                end
            end
            S_MERGE_RD: begin
                tree_req.raddr = node_of(r_j, r_addr ^ (AW'(1) << r_j));
                if (r_j == seg_s) begin
                    tree_req.we    = 1'b1;
                    tree_req.waddr = node_of(r_j, r_addr);
                    tree_req.wdata = 1'b1;
                end
            end
            S_MERGE_CHK: begin
                tree_req.we    = 1'b1;
                tree_req.waddr = tree_bit ? node_of(r_j, r_addr ^ (AW'(1) << r_j))
                                          : node_of(r_j, r_addr);
                tree_req.wdata = !tree_bit;
            end
            S_MERGE_CLR: begin
                tree_req.we    = 1'b1;
                tree_req.waddr = node_of(r_j, r_addr);
                tree_req.wdata = 1'b0;
            end
            default: ;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE) && !tree_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_seg    <= ORD_W'(SEG_RESET);
            r_frag   <= '0;
            r_ovalid <= 1'b0;
            r_ostat  <= STAT_OK;
            r_oaddr  <= '0;
            r_ofrag  <= '0;
        end else begin
            r_state <= n_state;
            r_frag  <= n_frag;
            if (i_cfg_we) begin
                r_seg <= i_cfg_data;
            end
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
                r_ostat  <= r_stat;
                r_oaddr  <= (r_stat == STAT_OK) ? r_raddr : '0;
                r_ofrag  <= r_frag;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_size  <= n_size;
        r_faddr <= n_faddr;
        r_k     <= n_k;
        r_j     <= n_j;
        r_idx   <= n_idx;
        r_addr  <= n_addr;
        r_stat  <= n_stat;
        r_raddr <= n_raddr;
    end

    always_ff @(posedge i_clk) begin
        if (bo_we) begin
            r_bo_mem[r_addr[AW-1:MIN_ORDER]] <= BO_W'(r_k - ORD_W'(MIN_ORDER));
        end
        r_bo_q <= r_bo_mem[r_addr[AW-1:MIN_ORDER]];
    end

    bba_tree u_tree (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_init      (i_cfg_we),
        .i_init_node (node_of(seg_clamp(i_cfg_data), '0)),
        .i_req       (tree_req),
        .o_rd_bit    (tree_bit),
        .o_busy      (tree_busy)
    );

    assign o_out_valid  = r_ovalid;
    assign o_status     = r_ostat;
    assign o_alloc_addr = r_oaddr;
    assign o_frag_total = r_ofrag;

endmodule

/* rtl/bba_checker.sv */
// bba_checker: port-level assertions for buddy_block_allocator, bound below
// depends on bba_pkg
module bba_checker import bba_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [1:0]        o_status,
    input logic [AW-1:0]     o_alloc_addr,
    input logic [FRAG_W-1:0] o_frag_total
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == STAT_OK || o_status == STAT_RANGE
                         || o_status == STAT_NOMEM))
        else $error("bad status code");

    a_err_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != STAT_OK |-> o_alloc_addr == '0)
        else $error("address on failed request");

    a_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == STAT_OK && o_alloc_addr != '0
        |-> o_alloc_addr[MIN_ORDER-1:0] == MIN_ORDER'(HEADER_BYTES))
        else $error("misaligned block address");

    a_frag_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> o_frag_total >= $past(o_frag_total))
        else $error("fragmentation total decreased");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_status     (o_status),
    .o_alloc_addr (o_alloc_addr),
    .o_frag_total (o_frag_total)
);

/* tb/tb_top.sv */
// tb_top: self-checking testbench for buddy_block_allocator
// runs a directed table, then random allocate/free traffic, against a behavioral predictor
// depends on bba_pkg and buddy_block_allocator
module tb_top;
    import bba_pkg::*;

    localparam int LIMIT = 40_000_000;

    typedef struct {
        t_status           st;
        logic [AW-1:0]     addr;
        logic [FRAG_W-1:0] frag;
    } alloc_result_t;

    typedef struct {
        bit                cfg;
        logic [ORD_W-1:0]  seg;
        logic              op;
        logic [SIZE_W-1:0] sz;
        logic [AW-1:0]     fa;
        bit                known;
        t_status           st;
        logic [AW-1:0]     ad;
    } dir_row_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [ORD_W-1:0]  i_cfg_data;
    logic              i_in_valid;
    logic              o_in_ready;
    logic              i_opcode;
    logic [SIZE_W-1:0] i_req_size;
    logic [AW-1:0]     i_free_addr;
    logic              o_out_valid;
    logic              i_out_ready = 1'b1;
    logic [1:0]        o_status;
    logic [AW-1:0]     o_alloc_addr;
    logic [FRAG_W-1:0] o_frag_total;

    buddy_block_allocator u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_req_size   (i_req_size),
        .i_free_addr  (i_free_addr),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_alloc_addr (o_alloc_addr),
        .o_frag_total (o_frag_total)
    );

    // model state
    bit                tree_free [2048];
    logic [3:0]        leaf_ord  [1024];
    bit                leaf_used [1024];
    logic [FRAG_W-1:0] frag_sum;
    logic [ORD_W-1:0]  seg_reg;

    alloc_result_t     pending_q [$];
    logic [AW-1:0]     live_q [$];
    int                errors = 0;
    int                cycles = 0;
    bit                sender_idle;
    bit                rcv_stall;
    bit                hold_ask;
    bit                hold_done = 1'b0;
    int                hold_cnt = 0;
    dir_row_t          dir_tab [19];

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned seg_now();
        int unsigned s;
        s = seg_reg;
        if (s < MIN_ORDER) s = MIN_ORDER;
        if (s > MAX_ORDER) s = MAX_ORDER;
        return s;
    endfunction

    function automatic int unsigned tnode(int unsigned o, int unsigned a);
        return ((32'd1 << (MAX_ORDER - o)) + (a >> o)) & 32'd2047;
    endfunction

    function automatic void tree_clear();
        foreach (tree_free[i]) tree_free[i] = 1'b0;
        tree_free[tnode(seg_now(), 0)] = 1'b1;
    endfunction

    function automatic alloc_result_t predict_buddy(logic op, logic [SIZE_W-1:0] sz,
                                                    logic [AW-1:0] fa);
        alloc_result_t r;
        int unsigned   s, k, j, a, o, bud, waste;
        bit            found;
        s = seg_now();
        r.st = STAT_OK;
        r.addr = '0;
        if (op == OP_ALLOC) begin
            if (sz < 128 || sz > 4096) begin
                r.st = STAT_RANGE;
            end else begin
                k = MIN_ORDER;
                while ((32'd1 << k) < sz + HEADER_BYTES) k++;
                found = 1'b0;
                a = 0;
                if (k <= s) begin
                    for (j = k; j <= s && !found; j++) begin
                        for (int unsigned idx = 0; idx < (32'd1 << (s - j)); idx++) begin
                            if (tree_free[tnode(j, idx << j)]) begin
                                a = idx << j;
                                found = 1'b1;
                                break;
                            end
                        end
                    end
                end
                if (!found) begin
                    r.st = STAT_NOMEM;
                end else begin
                    j--;
                    tree_free[tnode(j, a)] = 1'b0;
                    while (j > k) begin
                        j--;
                        tree_free[tnode(j, a + (32'd1 << j))] = 1'b1;
                    end
                    leaf_ord[(a >> MIN_ORDER) & 1023] = 4'(k - MIN_ORDER);
                    leaf_used[(a >> MIN_ORDER) & 1023] = 1'b1;
                    waste = (32'd1 << k) - sz - HEADER_BYTES;
                    if (waste > FRAG_MAX - frag_sum) frag_sum = FRAG_MAX;
                    else frag_sum = frag_sum + FRAG_W'(waste);
                    r.addr = AW'(a + HEADER_BYTES);
                end
            end
        end else begin
            a = (32'(fa) - HEADER_BYTES) & ((32'd1 << s) - 1);
            o = leaf_ord[(a >> MIN_ORDER) & 1023] + MIN_ORDER;
            if (o > s) o = s;
            a = a & ~((32'd1 << o) - 1);
            tree_free[tnode(o, a)] = 1'b1;
            while (o < s) begin
                bud = a ^ (32'd1 << o);
                if (!tree_free[tnode(o, bud)]) break;
                tree_free[tnode(o, bud)] = 1'b0;
                tree_free[tnode(o, a)] = 1'b0;
                a = a & ~(32'd1 << o);
                o++;
                tree_free[tnode(o, a)] = 1'b1;
            end
        end
        r.frag = frag_sum;
        return r;
    endfunction

    // called at a rising edge; after acceptance leaves valid high, or, when sender_idle, may drop it for a random pause
    task automatic issue(input logic op, input logic [SIZE_W-1:0] sz, input logic [AW-1:0] fa,
                         input bit known, input t_status st, input logic [AW-1:0] ad);
        alloc_result_t r;
        i_in_valid  <= 1'b1;
        i_opcode    <= op;
        i_req_size  <= sz;
        i_free_addr <= fa;
        do @(posedge i_clk); while (!o_in_ready);
        r = predict_buddy(op, sz, fa);
        if (op == OP_ALLOC && r.st == STAT_OK) live_q.push_back(r.addr);
        if (known) begin
            r.st = st;
            r.addr = ad;
        end
        pending_q.push_back(r);
        if (sender_idle && $urandom_range(99) < 68) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic write_seg(input logic [ORD_W-1:0] v);
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        seg_reg = v;
        tree_clear();
        live_q.delete();
    endtask

    task automatic random_item();
        int unsigned   pick, s, idx;
        logic [AW-1:0] fa;
        s = seg_now();
        pick = $urandom_range(99);
        if (pick < 45 && live_q.size() != 0) begin
            idx = $urandom_range(live_q.size() - 1);
            fa = live_q[idx];
            live_q.delete(idx);
            issue(OP_FREE, SIZE_W'($urandom), fa, 0, STAT_OK, '0);
        end else if (pick < 53) begin
            fa = AW'($urandom);
            if (leaf_used[(((32'(fa) - HEADER_BYTES) & ((32'd1 << s) - 1)) >> MIN_ORDER) & 1023])
                issue(OP_FREE, SIZE_W'($urandom), fa, 0, STAT_OK, '0);
            else
                issue(OP_ALLOC, SIZE_W'($urandom), fa, 0, STAT_OK, '0);
        end else if (pick < 70) begin
            issue(OP_ALLOC, SIZE_W'($urandom_range(128, 4096)), AW'($urandom), 0, STAT_OK, '0);
        end else begin
            issue(OP_ALLOC, SIZE_W'($urandom_range(128, 1012)), AW'($urandom), 0, STAT_OK, '0);
        end
    endtask

    // receiver
    always @(posedge i_clk) begin
        if (hold_ask && !hold_done) begin
            i_out_ready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt >= 400) hold_done <= 1'b1;
        end else if (rcv_stall) begin
            i_out_ready <= ($urandom_range(99) >= 68);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result status=%0d addr=%0d frag=%0d",
                         $time, o_status, o_alloc_addr, o_frag_total);
                errors++;
            end else begin
                if (o_status !== pending_q[0].st) begin
                    $display("%0t: status expected %0d got %0d", $time, pending_q[0].st, o_status);
                    errors++;
                end
                if (o_alloc_addr !== pending_q[0].addr) begin
                    $display("%0t: alloc_addr expected %0d got %0d",
                             $time, pending_q[0].addr, o_alloc_addr);
                    errors++;
                end
                if (o_frag_total !== pending_q[0].frag) begin
                    $display("%0t: frag_total expected %0d got %0d",
                             $time, pending_q[0].frag, o_frag_total);
                    errors++;
                end
                void'(pending_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial begin
        logic [ORD_W-1:0] phase_seg [6];
        int               wait_cnt;
        hold_ask = 1'b0;
        sender_idle = 1'b0;
        rcv_stall = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_opcode = OP_ALLOC;
        i_req_size = '0;
        i_free_addr = '0;
        phase_seg = '{5'd15, 5'd18, 5'd16, 5'd17, 5'd15, 5'd18};

        dir_tab[0]  = '{0, 0,  OP_ALLOC, 128,  0,    1, STAT_OK,    12};
        dir_tab[1]  = '{0, 0,  OP_ALLOC, 127,  0,    1, STAT_RANGE, 0};
        dir_tab[2]  = '{0, 0,  OP_ALLOC, 4097, 0,    1, STAT_RANGE, 0};
        dir_tab[3]  = '{0, 0,  OP_ALLOC, 0,    0,    1, STAT_RANGE, 0};
        dir_tab[4]  = '{0, 0,  OP_ALLOC, 8191, 0,    1, STAT_RANGE, 0};
        dir_tab[5]  = '{0, 0,  OP_ALLOC, 4096, 0,    0, STAT_OK,    0};
        dir_tab[6]  = '{0, 0,  OP_ALLOC, 4084, 0,    0, STAT_OK,    0};
        dir_tab[7]  = '{0, 0,  OP_FREE,  0,    12,   0, STAT_OK,    0};
        dir_tab[8]  = '{0, 0,  OP_FREE,  0,    12,   0, STAT_OK,    0};
        dir_tab[9]  = '{0, 0,  OP_ALLOC, 244,  0,    0, STAT_OK,    0};
        dir_tab[10] = '{0, 0,  OP_ALLOC, 245,  0,    0, STAT_OK,    0};
        dir_tab[11] = '{0, 0,  OP_FREE,  0,    8204, 0, STAT_OK,    0};
        dir_tab[12] = '{1, 0,  OP_ALLOC, 128,  0,    1, STAT_OK,    12};
        dir_tab[13] = '{0, 0,  OP_ALLOC, 128,  0,    1, STAT_NOMEM, 0};
        dir_tab[14] = '{0, 0,  OP_ALLOC, 4096, 0,    1, STAT_NOMEM, 0};
        dir_tab[15] = '{0, 0,  OP_FREE,  0,    12,   0, STAT_OK,    0};
        dir_tab[16] = '{0, 0,  OP_ALLOC, 200,  0,    1, STAT_OK,    12};
        dir_tab[17] = '{1, 31, OP_ALLOC, 4096, 0,    1, STAT_OK,    12};
        dir_tab[18] = '{0, 0,  OP_FREE,  0,    12,   0, STAT_OK,    0};

        seg_reg = 5'(SEG_RESET);
        frag_sum = '0;
        foreach (leaf_ord[i]) leaf_ord[i] = '0;
        foreach (leaf_used[i]) leaf_used[i] = 1'b0;
        tree_clear();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].cfg) write_seg(dir_tab[i].seg);
            issue(dir_tab[i].op, dir_tab[i].sz, dir_tab[i].fa,
                  dir_tab[i].known, dir_tab[i].st, dir_tab[i].ad);
        end

        for (int p = 0; p < 6; p++) begin
            write_seg(phase_seg[p]);
            sender_idle = (p % 4 == 1) || (p % 4 == 3);
            rcv_stall   = (p % 4 == 2) || (p % 4 == 3);
            if (p == 1) hold_ask = 1'b1;
            for (int n = 0; n < 215; n++) begin
                if (p % 4 == 3 && n % 60 > 40) begin
                    sender_idle = 1'b0;
                    rcv_stall = 1'b0;
                end else if (p % 4 == 3) begin
                    sender_idle = ($urandom_range(99) < 32);
                    rcv_stall = sender_idle;
                end
                random_item();
            end
        end

        i_in_valid <= 1'b0;
        wait_cnt = 0;
        while (pending_q.size() != 0 && wait_cnt < 500_000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending_q.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            if (pending_q.size() != 0)
                $display("%0t: %0d results never arrived", $time, pending_q.size());
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

/* buddy_block_allocator.f */
rtl/bba_pkg.sv
rtl/bba_tree.sv
rtl/buddy_block_allocator.sv
rtl/bba_checker.sv
tb/tb_top.sv
